>>> hdl/periodic_priority_task_scheduler_macros.svh
// Assertion macros used by the scheduler datapath.
`ifndef PERIODIC_PRIORITY_TASK_SCHEDULER_MACROS_SVH
`define PERIODIC_PRIORITY_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PPTS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler assertion failed");

// Next-cycle implication, disabled while reset is high.
`define PPTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler assertion failed");

`endif

>>> hdl/ppts_pkg.sv
// Types and constants of the periodic priority task scheduler.
package ppts_pkg;

   localparam int MAX_RESULTS = 8;
   localparam int DN_W = 4;

   localparam logic [1:0] ACT_TICK   = 2'd0;
   localparam logic [1:0] ACT_CREATE = 2'd1;
   localparam logic [1:0] ACT_DELETE = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam logic [1:0] KIND_CREATE   = 2'd0;
   localparam logic [1:0] KIND_DELETE   = 2'd1;
   localparam logic [1:0] KIND_DISPATCH = 2'd2;
   localparam logic [1:0] KIND_NONE     = 2'd3;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef enum logic [1:0] {
      TASK_READY   = 2'd0,
      TASK_WAITING = 2'd1,
      TASK_IDLE    = 2'd2
   } task_state_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_CREATE,
      S_DELETE,
      S_UPDATE,
      S_SCAN_START,
      S_SCAN,
      S_DISPATCH,
      S_NONE
   } ctrl_state_type;

   typedef struct packed {
      logic latch_req;
      logic tick_start;
      logic idx_last;
      logic upd_step;
      logic scan_clr;
      logic scan_step;
      logic dispatch;
      logic none_rsp;
      logic create_do;
      logic delete_do;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       idx_end;
      logic       more;
      logic       ready_zero;
      logic       rsp_space;
   } stat_type;

endpackage

>>> hdl/ppts_req_if.sv
// Request channel interface of the scheduler.
interface ppts_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [7:0]  priority_req;
   logic [15:0] period;
   logic        handler_valid;
   logic [2:0]  task_slot;

   modport source (output valid, action, priority_req, period, handler_valid, task_slot,
                   input ready);
   modport sink (input valid, action, priority_req, period, handler_valid, task_slot,
                 output ready);
endinterface

>>> hdl/ppts_rsp_if.sv
// Response channel interface of the scheduler.
interface ppts_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic       status;
   logic [2:0] dispatched_slot;
   logic       last;

   modport source (output valid, kind, status, dispatched_slot, last, input ready);
   modport sink (input valid, kind, status, dispatched_slot, last, output ready);
endinterface

>>> hdl/periodic_priority_task_scheduler.sv
// Top level of the periodic fixed-priority task scheduler.
//
//   Channel   Direction  Handshake     Payload
//   req_chan  in         valid/ready   action, priority_req, period, handler_valid, task_slot
//   rsp_chan  out        valid/ready   kind, status, dispatched_slot, last
//
// One transaction is in work at a time; a create or delete goes through decode and then
// its own state, which loads the response. A tick runs an update pass, then one priority
// scan per dispatch, each one entry per cycle; with nothing ready it loads a none response.
// Reset clears the controller, the fill count and all task states to idle.
// A stalled response holds the block at its next response; requests wait in req_chan.
module periodic_priority_task_scheduler #(
   parameter int MAX_TASKS = 8
) (
   input logic         clock,
   input logic         reset,
   ppts_req_if.sink    req_chan,
   ppts_rsp_if.source  rsp_chan
);
   import ppts_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ppts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   ppts_datapath #(
      .MAX_TASKS (MAX_TASKS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_action          (req_chan.action),
      .req_priority_req    (req_chan.priority_req),
      .req_period          (req_chan.period),
      .req_handler_valid   (req_chan.handler_valid),
      .req_task_slot       (req_chan.task_slot),
      .rsp_ready           (rsp_chan.ready),
      .rsp_valid           (rsp_chan.valid),
      .rsp_kind            (rsp_chan.kind),
      .rsp_status          (rsp_chan.status),
      .rsp_dispatched_slot (rsp_chan.dispatched_slot),
      .rsp_last            (rsp_chan.last)
   );

endmodule

>>> hdl/ppts_datapath.sv
// Task table, scan logic and response register of the scheduler.
`include "periodic_priority_task_scheduler_macros.svh"

module ppts_datapath #(
   parameter int MAX_TASKS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  ppts_pkg::cmd_type  cmd,
   output ppts_pkg::stat_type stat,
   input  logic [1:0]        req_action,
   input  logic [7:0]        req_priority_req,
   input  logic [15:0]       req_period,
   input  logic              req_handler_valid,
   input  logic [2:0]        req_task_slot,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [1:0]        rsp_kind,
   output logic              rsp_status,
   output logic [2:0]        rsp_dispatched_slot,
   output logic              rsp_last
);
   import ppts_pkg::*;

   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);
   localparam int LW = (CW > DN_W) ? CW : DN_W;
   localparam int SW = (CW > 3) ? CW : 3;

   logic [1:0]  action_ff;
   logic [7:0]  prio_ff;
   logic [15:0] period_ff;
   logic        hv_ff;
   logic [2:0]  slot_ff;

   logic [15:0]    ent_period_ff [MAX_TASKS];
   logic [7:0]     ent_prio_ff   [MAX_TASKS];
   logic [15:0]    ent_ticks_ff  [MAX_TASKS];
   task_state_type ent_state_ff  [MAX_TASKS];

   logic [CW-1:0]   count_ff, count_in;
   logic [IW-1:0]   idx_ff, idx_in;
   logic [CW-1:0]   ready_cnt_ff, ready_cnt_in;
   logic [DN_W-1:0] disp_n_ff, disp_n_in;
   logic            found_ff, found_in;
   logic [IW-1:0]   best_ff, best_in;
   logic [7:0]      best_prio_ff, best_prio_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_kind_ff, rsp_kind_in;
   logic       rsp_status_ff, rsp_status_in;
   logic [2:0] rsp_slot_ff, rsp_slot_in;
   logic       rsp_last_ff, rsp_last_in;

   logic [15:0]    rd_period;
   logic [7:0]     rd_prio;
   logic [15:0]    rd_ticks;
   task_state_type rd_state;
   logic [16:0]    tick_sum;
   logic           upd_due;
   logic           upd_ready;
   logic           scan_hit;
   logic           create_ok;
   logic           delete_ok;
   logic [IW-1:0]  create_idx;
   logic [IW-1:0]  del_idx;
   logic [LW-1:0]  limit;
   logic           rsp_space;
   logic           rsp_load;
   logic           disp_last;

   assign rd_period = ent_period_ff[idx_ff];
   assign rd_prio   = ent_prio_ff[idx_ff];
   assign rd_ticks  = ent_ticks_ff[idx_ff];
   assign rd_state  = ent_state_ff[idx_ff];

   assign tick_sum  = {1'b0, rd_ticks} + 17'd1;
   assign upd_due   = tick_sum >= {1'b0, rd_period};
   assign upd_ready = (rd_state == TASK_READY) || ((rd_state == TASK_WAITING) && upd_due);
   assign scan_hit  = (rd_state == TASK_READY) && (!found_ff || (rd_prio >= best_prio_ff));

   assign create_ok  = (period_ff != 16'd0) && hv_ff && (count_ff < CW'(MAX_TASKS));
   assign delete_ok  = (count_ff != '0) && (SW'(slot_ff) < SW'(count_ff));
   assign create_idx = IW'(count_ff);
   assign del_idx    = IW'(slot_ff);

   assign limit = (LW'(ready_cnt_ff) > LW'(MAX_RESULTS)) ? LW'(MAX_RESULTS) : LW'(ready_cnt_ff);
   assign disp_last = (LW'(disp_n_ff + DN_W'(1)) == limit);

   assign rsp_space = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = cmd.create_do || cmd.delete_do || cmd.dispatch || cmd.none_rsp;

   always_comb begin
      stat.action     = action_ff;
      stat.idx_end    = (idx_ff == IW'(MAX_TASKS - 1));
      stat.more       = (LW'(disp_n_ff) < limit);
      stat.ready_zero = (ready_cnt_ff == '0);
      stat.rsp_space  = rsp_space;
   end

   always_comb begin
      idx_in       = idx_ff;
      ready_cnt_in = ready_cnt_ff;
      disp_n_in    = disp_n_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      best_prio_in = best_prio_ff;
      count_in     = count_ff;
      if (cmd.tick_start) begin
         idx_in       = '0;
         ready_cnt_in = '0;
         disp_n_in    = '0;
      end
      if (cmd.idx_last) begin
         idx_in = IW'(count_ff - CW'(1));
      end
      if (cmd.upd_step) begin
         idx_in = idx_ff + IW'(1);
         if (upd_ready) begin
            ready_cnt_in = ready_cnt_ff + CW'(1);
         end
      end
      if (cmd.scan_clr) begin
         idx_in   = '0;
         found_in = 1'b0;
      end
      if (cmd.scan_step) begin
         idx_in = idx_ff + IW'(1);
         if (scan_hit) begin
            found_in     = 1'b1;
            best_in      = idx_ff;
            best_prio_in = rd_prio;
         end
      end
      if (cmd.dispatch) begin
         disp_n_in = disp_n_ff + DN_W'(1);
      end
      if (cmd.create_do && create_ok) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.delete_do && delete_ok) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_last_in   = rsp_last_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = STATUS_OK;
         rsp_slot_in   = 3'd0;
         rsp_last_in   = 1'b1;
         if (cmd.create_do) begin
            rsp_kind_in   = KIND_CREATE;
            rsp_status_in = create_ok ? STATUS_OK : STATUS_REJECT;
            rsp_slot_in   = create_ok ? 3'(count_ff) : 3'd0;
         end else if (cmd.delete_do) begin
            rsp_kind_in   = KIND_DELETE;
            rsp_status_in = delete_ok ? STATUS_OK : STATUS_REJECT;
         end else if (cmd.dispatch) begin
            rsp_kind_in = KIND_DISPATCH;
            rsp_slot_in = 3'(best_ff);
            rsp_last_in = disp_last;
         end else begin
            rsp_kind_in = KIND_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         action_ff <= req_action;
         prio_ff   <= req_priority_req;
         period_ff <= req_period;
         hv_ff     <= req_handler_valid;
         slot_ff   <= req_task_slot;
      end
      idx_ff       <= idx_in;
      best_ff      <= best_in;
      best_prio_ff <= best_prio_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ready_cnt_ff <= '0;
         disp_n_ff    <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ready_cnt_ff <= ready_cnt_in;
         disp_n_ff    <= disp_n_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.upd_step && (rd_state == TASK_WAITING)) begin
         ent_ticks_ff[idx_ff] <= upd_due ? 16'd0 : tick_sum[15:0];
      end
      if (cmd.create_do && create_ok) begin
         ent_period_ff[create_idx] <= period_ff;
         ent_prio_ff[create_idx]   <= prio_ff;
         ent_ticks_ff[create_idx]  <= 16'd0;
      end
      if (cmd.delete_do && delete_ok) begin
         ent_period_ff[del_idx] <= rd_period;
         ent_prio_ff[del_idx]   <= rd_prio;
         ent_ticks_ff[del_idx]  <= rd_ticks;
      end
      if (cmd.dispatch) begin
         ent_ticks_ff[best_ff] <= 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TASKS; i++) begin
            ent_state_ff[i] <= TASK_IDLE;
         end
      end else begin
         if (cmd.upd_step && (rd_state == TASK_WAITING) && upd_due) begin
            ent_state_ff[idx_ff] <= TASK_READY;
         end
         if (cmd.create_do && create_ok) begin
            ent_state_ff[create_idx] <= TASK_READY;
         end
         if (cmd.delete_do && delete_ok) begin
            if (del_idx != idx_ff) begin
               ent_state_ff[del_idx] <= rd_state;
            end
            ent_state_ff[idx_ff] <= TASK_IDLE;
         end
         if (cmd.dispatch) begin
            ent_state_ff[best_ff] <= TASK_WAITING;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_kind_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_dispatched_slot = rsp_slot_ff;
   assign rsp_last            = rsp_last_ff;

   // The table never holds more entries than it has slots.
   `PPTS_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff <= CW'(MAX_TASKS))
   // A response is only loaded when the output register is free or draining.
   `PPTS_ASSERT_NOW(a_load_space, clock, reset, rsp_load, rsp_space)
   // A dispatch always refers to a task that the scan found ready.
   `PPTS_ASSERT_NOW(a_dispatch_found, clock, reset, cmd.dispatch, found_ff && (ent_state_ff[best_ff] == TASK_READY))
   // An accepted create grows the table by exactly one entry.
   `PPTS_ASSERT_NEXT(a_create_grows, clock, reset, cmd.create_do && create_ok, count_ff == ($past(count_ff) + CW'(1)))

endmodule

>>> hdl/ppts_ctrl.sv
// Control state machine of the scheduler.
module ppts_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output ppts_pkg::cmd_type  cmd,
   input  ppts_pkg::stat_type stat
);
   import ppts_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.action)
               ACT_TICK:   state_in = S_UPDATE;
               ACT_CREATE: state_in = S_CREATE;
               ACT_DELETE: state_in = S_DELETE;
               default:    state_in = S_IDLE;
            endcase
         end
         S_CREATE, S_DELETE, S_NONE: begin
            if (stat.rsp_space) begin
               state_in = S_IDLE;
            end
         end
         S_UPDATE: begin
            if (stat.idx_end) begin
               state_in = S_SCAN_START;
            end
         end
         S_SCAN_START: begin
            if (stat.more) begin
               state_in = S_SCAN;
            end else if (stat.ready_zero) begin
               state_in = S_NONE;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (stat.idx_end) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (stat.rsp_space) begin
               state_in = S_SCAN_START;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready     = 1'b1;
            cmd.latch_req = req_valid;
         end
         S_DECODE: begin
            cmd.tick_start = (stat.action == ACT_TICK);
            cmd.idx_last   = (stat.action == ACT_DELETE);
         end
         S_CREATE:     cmd.create_do = stat.rsp_space;
         S_DELETE:     cmd.delete_do = stat.rsp_space;
         S_UPDATE:     cmd.upd_step  = 1'b1;
         S_SCAN_START: cmd.scan_clr  = 1'b1;
         S_SCAN:       cmd.scan_step = 1'b1;
         S_DISPATCH:   cmd.dispatch  = stat.rsp_space;
         S_NONE:       cmd.none_rsp  = stat.rsp_space;
         default:      cmd = '0;
      endcase
   end

endmodule
